### rtl/core/mbws_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window burst sum package
// Shared widths, register map and constants for the burst window sum core.
// ----------------------------------------------------------------------------
package mbws_pkg;

  localparam int SUM_BITS   = 34;
  localparam int WIN_BITS   = 40;
  localparam int PADDR_BITS = 4;
  localparam int PDATA_BITS = 64;

  localparam logic [SUM_BITS-1:0] SUM_MAX   = {SUM_BITS{1'b1}};
  localparam logic [WIN_BITS-1:0] WIN_RESET = 40'd500000;

  // Register index, taken from paddr above the 8-byte register offset.
  localparam logic [PADDR_BITS-4:0] REG_WINDOW = '0;

endpackage

### rtl/core/max_burst_window_sum_core.sv
// ----------------------------------------------------------------------------
// Sliding time window maximum byte sum
// Keeps timed arrivals in a circular memory and tracks the in-window byte sum.
// ----------------------------------------------------------------------------
// Arrivals come in on the arr channel (timestamp_us, unit_bytes) and each one
// produces exactly one transfer on the res channel (window_bytes, best_bytes,
// overflowed). The window length is written through the APB port at byte
// address 0; the user must write it only while the core is idle, as the core
// itself does not enforce this. pready is always high.
// After an arrival transfer the core evicts, one at a time, each entry that
// has fallen out of the window, then stores the arrival (overwriting the
// oldest entry when the memory is full), then forms the result in its output
// register; a new arrival may be taken as that result is written. Each stored
// entry is evicted at most once. Eviction is paced by the single read port of
// the arrival memory, which reads one oldest entry each cycle.
// Reset is synchronous and clears the pointers, count, sums and overflow
// flag; the arrival memory needs no clearing. When the receiver stalls the
// result stays in its output register, and one further arrival may be taken
// and processed up to the point where it waits for the output register.
// ----------------------------------------------------------------------------
module max_burst_window_sum_core
  import mbws_pkg::*;
#(
  parameter int WINDOW_DEPTH = 1024,
  parameter int TIME_BITS    = 40,
  parameter int SIZE_BITS    = 24
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,

  input  logic                  arr_valid,
  output logic                  arr_ready,
  input  logic [TIME_BITS-1:0]  timestamp_us,
  input  logic [SIZE_BITS-1:0]  unit_bytes,

  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [SUM_BITS-1:0]   window_bytes,
  output logic [SUM_BITS-1:0]   best_bytes,
  output logic                  overflowed
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = SIZE_BITS + CW;
  localparam int XW = (SW > SUM_BITS) ? SW : SUM_BITS;
  localparam int DW = (TIME_BITS > WIN_BITS) ? TIME_BITS : WIN_BITS;
  localparam int MW = TIME_BITS + SIZE_BITS;

  typedef enum logic [1:0] {
    IDLE,
    CHECK,
    FINISH
  } state_t;

  state_t                state;
  logic [WIN_BITS-1:0]   window_len;
  logic [AW-1:0]         oldest_slot;
  logic [CW-1:0]         entry_count;
  logic [SW-1:0]         running_sum;
  logic [SUM_BITS-1:0]   best_sum;
  logic                  overflow_flag;
  logic [TIME_BITS-1:0]  arr_time;
  logic [SIZE_BITS-1:0]  arr_size;

  logic [MW-1:0]         fifo_mem [WINDOW_DEPTH];
  logic [MW-1:0]         rd_data;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  wr_en;

  logic [TIME_BITS-1:0]  old_time;
  logic [SIZE_BITS-1:0]  old_size;
  logic [TIME_BITS-1:0]  time_gap;
  logic                  too_old;
  logic                  is_full;
  logic [AW-1:0]         oldest_inc;
  logic [AW:0]           tail_sum;
  logic [AW-1:0]         tail_slot;
  logic                  cfg_write;
  logic                  arr_take;
  logic                  out_free;
  logic [XW-1:0]         sum_ext;
  logic [SUM_BITS-1:0]   sum_sat;
  logic [SUM_BITS-1:0]   best_new;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[PADDR_BITS-1:3] == REG_WINDOW);
  assign prdata    = (paddr[PADDR_BITS-1:3] == REG_WINDOW) ?
                     PDATA_BITS'(window_len) : '0;

  assign old_time = rd_data[MW-1:SIZE_BITS];
  assign old_size = rd_data[SIZE_BITS-1:0];
  assign time_gap = arr_time - old_time;
  assign too_old  = (entry_count != '0) && (arr_time > old_time)
                    && (DW'(time_gap) > DW'(window_len));
  assign is_full  = (entry_count == CW'(WINDOW_DEPTH));

  assign oldest_inc = (oldest_slot == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_slot + 1'b1;
  assign tail_sum   = (AW + 1)'(oldest_slot) + (AW + 1)'(entry_count);
  assign tail_slot  = (tail_sum >= (AW + 1)'(WINDOW_DEPTH)) ?
                      AW'(tail_sum - (AW + 1)'(WINDOW_DEPTH)) : AW'(tail_sum);

  assign out_free  = !res_valid || res_ready;
  assign arr_ready = (state == IDLE) || ((state == FINISH) && out_free);
  assign arr_take  = arr_valid && arr_ready;

  assign wr_en   = (state == CHECK) && !too_old;
  assign wr_addr = is_full ? oldest_slot : tail_slot;
  assign rd_addr = ((state == CHECK) && (too_old || is_full)) ? oldest_inc : oldest_slot;

  assign sum_ext  = XW'(running_sum);
  assign sum_sat  = (sum_ext > XW'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_BITS-1:0];
  assign best_new = (sum_sat > best_sum) ? sum_sat : best_sum;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_mem[wr_addr] <= {arr_time, arr_size};
    end
    rd_data <= fifo_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      window_len    <= WIN_RESET;
      oldest_slot   <= '0;
      entry_count   <= '0;
      running_sum   <= '0;
      best_sum      <= '0;
      overflow_flag <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        window_len <= pwdata[WIN_BITS-1:0];
      end
      if (res_valid && res_ready && !((state == FINISH) && out_free)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (arr_take) begin
            arr_time <= timestamp_us;
            arr_size <= unit_bytes;
            state    <= CHECK;
          end
        end
        CHECK: begin
          if (too_old) begin
            running_sum <= running_sum - SW'(old_size);
            oldest_slot <= oldest_inc;
            entry_count <= entry_count - 1'b1;
          end else if (is_full) begin
            running_sum   <= running_sum - SW'(old_size) + SW'(arr_size);
            oldest_slot   <= oldest_inc;
            overflow_flag <= 1'b1;
            state         <= FINISH;
          end else begin
            running_sum <= running_sum + SW'(arr_size);
            entry_count <= entry_count + 1'b1;
            state       <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            res_valid    <= 1'b1;
            window_bytes <= sum_sat;
            best_bytes   <= best_new;
            best_sum     <= best_new;
            overflowed   <= overflow_flag;
            if (arr_take) begin
              arr_time <= timestamp_us;
              arr_size <= unit_bytes;
              state    <= CHECK;
            end else begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
